// ----- hdl/pcvs_pkg.sv -----
// Shared constants, codes and types for the path corridor visited splice unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pcvs_pkg;

  localparam int MAX_CORRIDOR = 256;
  localparam int MAX_VISITED  = 16;

  localparam int REF_W  = 32;
  localparam int RIDX_W = 8;
  localparam int LEN_W  = 9;

  localparam int CA_W  = $clog2(MAX_CORRIDOR);
  localparam int CC_W  = $clog2(MAX_CORRIDOR + 1);
  localparam int VA_W  = (MAX_VISITED > 1) ? $clog2(MAX_VISITED) : 1;
  localparam int VC_W  = $clog2(MAX_VISITED + 1);
  localparam int CMP_W = (CC_W > RIDX_W) ? CC_W : RIDX_W;
  localparam int SZ_W  = ((CC_W > VC_W) ? CC_W : VC_W) + 1;

  typedef enum logic [1:0] {
    MODE_COR  = 2'd0,
    MODE_VIS  = 2'd1,
    MODE_READ = 2'd2,
    MODE_NOP  = 2'd3
  } mode_t;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_RD     = 10'b00_0000_0010,
    ST_SC_RD  = 10'b00_0000_0100,
    ST_SC_CMP = 10'b00_0000_1000,
    ST_CALC   = 10'b00_0001_0000,
    ST_CLIP   = 10'b00_0010_0000,
    ST_MV_RD  = 10'b00_0100_0000,
    ST_MV_WR  = 10'b00_1000_0000,
    ST_VW     = 10'b01_0000_0000,
    ST_DONE   = 10'b10_0000_0000
  } state_t;

  typedef struct packed {
    logic             en;
    logic             first;
    logic             last;
    logic [REF_W-1:0] poly_ref;
  } vis_app_t;

  typedef struct packed {
    logic            ovf;
    logic [VC_W-1:0] nvis;
  } vis_stat_t;

  typedef struct packed {
    logic            hit;
    logic [VA_W-1:0] idx;
  } vis_hit_t;

endpackage

// ----- hdl/pcvs_cor_ram.sv -----
// Corridor store: single write port, single read port, registered read data.
// Depends on pcvs_pkg for depth and widths.
`timescale 1ns / 1ps

module pcvs_cor_ram
  import pcvs_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [CA_W-1:0]  waddr,
  input  logic [REF_W-1:0] wdata,
  input  logic [CA_W-1:0]  raddr,
  output logic [REF_W-1:0] rdata
);

  logic [REF_W-1:0] mem [MAX_CORRIDOR];
  logic [REF_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/pcvs_vis_list.sv -----
// Visited list: register file with fill count, parallel match against one
// corridor entry (lowest index wins) and one indexed read. Depends on pcvs_pkg.
`timescale 1ns / 1ps

module pcvs_vis_list
  import pcvs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  vis_app_t         app,
  output vis_stat_t        stat,
  input  logic [VC_W-1:0]  cmp_nvis,
  input  logic [REF_W-1:0] cmp_ref,
  output vis_hit_t         hit,
  input  logic [VA_W-1:0]  rd_idx,
  output logic [REF_W-1:0] rd_ref
);

  logic [REF_W-1:0] vis_mem [MAX_VISITED];
  logic [VC_W-1:0]  cnt_r;
  logic [VC_W-1:0]  cnt_nxt;
  logic [VC_W-1:0]  eff;
  logic             fits;

  always_comb begin
    eff      = app.first ? '0 : cnt_r;
    fits     = (eff < VC_W'(MAX_VISITED));
    stat.ovf = !fits;
    stat.nvis = fits ? (eff + VC_W'(1)) : eff;
    cnt_nxt  = cnt_r;
    if (app.en) begin
      cnt_nxt = app.last ? '0 : stat.nvis;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (app.en && fits) begin
      vis_mem[eff[VA_W-1:0]] <= app.poly_ref;
    end
  end

  always_comb begin
    hit.hit = 1'b0;
    hit.idx = '0;
    for (int j = MAX_VISITED - 1; j >= 0; j--) begin
      if ((VC_W'(j) < cmp_nvis) && (vis_mem[j] == cmp_ref)) begin
        hit.hit = 1'b1;
        hit.idx = VA_W'(j);
      end
    end
  end

  assign rd_ref = vis_mem[rd_idx];

endmodule

// ----- hdl/path_corridor_visited_splice_unit.sv -----
// Top level of the path corridor visited splice unit: handshake, sequencer
// and output register. Depends on pcvs_pkg, pcvs_cor_ram and pcvs_vis_list.
`timescale 1ns / 1ps

// Corridor appends, visited appends without last and no-ops may follow one
// another every cycle while out_stall is low. A read passes through ST_RD
// because the corridor memory returns registered data in the cycle after the
// address. A visited beat with last runs the fixup on the corridor memory: it
// scans corridor entries from the end until the first hit (the whole corridor
// when nothing matches), moves the tail entries behind the hit and then
// splices in the visited entries. in_stall stays high while it runs and
// while a finished result is held by out_stall. No reset sweep is needed.

module path_corridor_visited_splice_unit
  import pcvs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_mode,
  input  logic [REF_W-1:0]  in_poly_ref,
  input  logic              in_first,
  input  logic              in_last,
  input  logic [RIDX_W-1:0] in_read_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [LEN_W-1:0]  out_corridor_len,
  output logic [REF_W-1:0]  out_read_ref,
  output logic              out_matched,
  output logic              out_overflow
);

  state_t           state_r, state_nxt;
  logic [CC_W-1:0]  cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0] out_len_r, out_len_nxt;
  logic [REF_W-1:0] out_ref_r, out_ref_nxt;
  logic             out_mat_r, out_mat_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic [CA_W-1:0]  scan_r, scan_nxt;
  logic [CA_W-1:0]  fpath_r, fpath_nxt;
  logic [VA_W-1:0]  fvis_r, fvis_nxt;
  logic [VC_W-1:0]  nvis_r, nvis_nxt;
  logic             fovf_r, fovf_nxt;
  logic             fmatch_r, fmatch_nxt;
  logic [CC_W-1:0]  req_r, req_nxt;
  logic [CC_W-1:0]  size_r, size_nxt;
  logic [CA_W-1:0]  src_r, src_nxt;
  logic [CA_W-1:0]  dst_r, dst_nxt;
  logic             up_r, up_nxt;
  logic [CC_W-1:0]  left_r, left_nxt;
  logic [CA_W-1:0]  k_r, k_nxt;
  logic [VA_W-1:0]  vptr_r, vptr_nxt;
  logic [CC_W-1:0]  newcnt_r, newcnt_nxt;
  logic             rd_ok_r, rd_ok_nxt;

  logic             acc;
  logic             out_take;
  logic             out_ld;

  logic             ram_we;
  logic [CA_W-1:0]  ram_waddr;
  logic [REF_W-1:0] ram_wdata;
  logic [CA_W-1:0]  ram_raddr;
  logic [REF_W-1:0] ram_rdata;

  vis_app_t         vis_app;
  vis_stat_t        vis_stat;
  vis_hit_t         vis_hit;
  logic [REF_W-1:0] vis_rd_ref;

  logic [CC_W-1:0]  cor_eff;
  logic             cor_fits;
  logic [CMP_W-1:0] ridx_ext;
  logic [SZ_W-1:0]  req_w;
  logic [CC_W-1:0]  limit;
  logic [CC_W-1:0]  size_c;
  logic [CC_W-1:0]  fpath_ext;

  pcvs_cor_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pcvs_vis_list u_vis (
    .clk      (clk),
    .rst_n    (rst_n),
    .app      (vis_app),
    .stat     (vis_stat),
    .cmp_nvis (nvis_r),
    .cmp_ref  (ram_rdata),
    .hit      (vis_hit),
    .rd_idx   (vptr_r),
    .rd_ref   (vis_rd_ref)
  );

  assign out_take = out_valid_r && !out_stall;
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign acc      = in_valid && !in_stall;

  assign cor_eff   = in_first ? '0 : cnt_r;
  assign cor_fits  = (cor_eff < CC_W'(MAX_CORRIDOR));
  assign ridx_ext  = CMP_W'(in_read_index);
  assign fpath_ext = CC_W'(fpath_r);

  always_comb begin
    vis_app.en       = acc && (in_mode == MODE_VIS);
    vis_app.first    = in_first;
    vis_app.last     = in_last;
    vis_app.poly_ref = in_poly_ref;
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    out_ld      = 1'b0;
    out_len_nxt = out_len_r;
    out_ref_nxt = out_ref_r;
    out_mat_nxt = out_mat_r;
    out_ovf_nxt = out_ovf_r;
    scan_nxt    = scan_r;
    fpath_nxt   = fpath_r;
    fvis_nxt    = fvis_r;
    nvis_nxt    = nvis_r;
    fovf_nxt    = fovf_r;
    fmatch_nxt  = fmatch_r;
    req_nxt     = req_r;
    size_nxt    = size_r;
    src_nxt     = src_r;
    dst_nxt     = dst_r;
    up_nxt      = up_r;
    left_nxt    = left_r;
    k_nxt       = k_r;
    vptr_nxt    = vptr_r;
    newcnt_nxt  = newcnt_r;
    rd_ok_nxt   = rd_ok_r;
    ram_we      = 1'b0;
    ram_waddr   = dst_r;
    ram_wdata   = ram_rdata;
    ram_raddr   = scan_r;
    req_w       = SZ_W'(nvis_r - VC_W'(fvis_r));
    limit       = CC_W'(MAX_CORRIDOR) - req_r;
    size_c      = (size_r < limit) ? size_r : limit;

    case (state_r)
      ST_IDLE: begin
        ram_raddr = ridx_ext[CA_W-1:0];
        if (acc) begin
          case (in_mode)
            MODE_COR: begin
              out_ld      = 1'b1;
              out_ref_nxt = '0;
              out_mat_nxt = 1'b0;
              out_ovf_nxt = !cor_fits;
              ram_waddr   = cor_eff[CA_W-1:0];
              ram_wdata   = in_poly_ref;
              if (cor_fits) begin
                ram_we  = 1'b1;
                cnt_nxt = cor_eff + CC_W'(1);
              end else begin
                cnt_nxt = cor_eff;
              end
              out_len_nxt = LEN_W'(cnt_nxt);
            end
            MODE_VIS: begin
              if (in_last) begin
                nvis_nxt   = vis_stat.nvis;
                fovf_nxt   = vis_stat.ovf;
                fmatch_nxt = 1'b0;
                scan_nxt   = CA_W'(cnt_r - CC_W'(1));
                state_nxt  = (cnt_r == '0) ? ST_DONE : ST_SC_RD;
              end else begin
                out_ld      = 1'b1;
                out_len_nxt = LEN_W'(cnt_r);
                out_ref_nxt = '0;
                out_mat_nxt = 1'b0;
                out_ovf_nxt = vis_stat.ovf;
              end
            end
            MODE_READ: begin
              rd_ok_nxt = (ridx_ext < CMP_W'(cnt_r));
              state_nxt = ST_RD;
            end
            default: begin
              out_ld      = 1'b1;
              out_len_nxt = LEN_W'(cnt_r);
              out_ref_nxt = '0;
              out_mat_nxt = 1'b0;
              out_ovf_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_RD: begin
        out_ld      = 1'b1;
        out_len_nxt = LEN_W'(cnt_r);
        out_ref_nxt = rd_ok_r ? ram_rdata : '0;
        out_mat_nxt = 1'b0;
        out_ovf_nxt = !rd_ok_r;
        state_nxt   = ST_IDLE;
      end
      ST_SC_RD: begin
        ram_raddr = scan_r;
        state_nxt = ST_SC_CMP;
      end
      ST_SC_CMP: begin
        if (vis_hit.hit) begin
          fpath_nxt = scan_r;
          fvis_nxt  = vis_hit.idx;
          state_nxt = ST_CALC;
        end else if (scan_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          scan_nxt  = scan_r - CA_W'(1);
          state_nxt = ST_SC_RD;
        end
      end
      ST_CALC: begin
        req_nxt   = (req_w > SZ_W'(MAX_CORRIDOR)) ? CC_W'(MAX_CORRIDOR) : CC_W'(req_w);
        size_nxt  = cnt_r - fpath_ext - CC_W'(1);
        state_nxt = ST_CLIP;
      end
      ST_CLIP: begin
        up_nxt     = (req_r > (fpath_ext + CC_W'(1)));
        newcnt_nxt = req_r + size_c;
        left_nxt   = size_c;
        if (up_nxt) begin
          src_nxt = CA_W'(fpath_ext + size_c);
          dst_nxt = CA_W'(req_r + size_c - CC_W'(1));
        end else begin
          src_nxt = CA_W'(fpath_ext + CC_W'(1));
          dst_nxt = CA_W'(req_r);
        end
        k_nxt     = '0;
        vptr_nxt  = VA_W'(nvis_r - VC_W'(1));
        state_nxt = (size_c == '0) ? ST_VW : ST_MV_RD;
      end
      ST_MV_RD: begin
        ram_raddr = src_r;
        state_nxt = ST_MV_WR;
      end
      ST_MV_WR: begin
        ram_we    = 1'b1;
        ram_waddr = dst_r;
        ram_wdata = ram_rdata;
        src_nxt   = up_r ? (src_r - CA_W'(1)) : (src_r + CA_W'(1));
        dst_nxt   = up_r ? (dst_r - CA_W'(1)) : (dst_r + CA_W'(1));
        left_nxt  = left_r - CC_W'(1);
        if (left_r == CC_W'(1)) begin
          left_nxt  = req_r;
          state_nxt = ST_VW;
        end else begin
          state_nxt = ST_MV_RD;
        end
      end
      ST_VW: begin
        ram_we    = 1'b1;
        ram_waddr = k_r;
        ram_wdata = vis_rd_ref;
        k_nxt     = k_r + CA_W'(1);
        vptr_nxt  = vptr_r - VA_W'(1);
        if (k_r == CA_W'(req_r - CC_W'(1))) begin
          fmatch_nxt = 1'b1;
          state_nxt  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (fmatch_r) begin
          cnt_nxt = newcnt_r;
        end
        out_ld      = 1'b1;
        out_len_nxt = LEN_W'(cnt_nxt);
        out_ref_nxt = '0;
        out_mat_nxt = fmatch_r;
        out_ovf_nxt = fovf_r;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (state_r == ST_CLIP && size_c == '0) begin
      left_nxt = req_r;
    end
  end

  assign out_valid_nxt = out_ld ? 1'b1 : (out_take ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_len_r <= out_len_nxt;
      out_ref_r <= out_ref_nxt;
      out_mat_r <= out_mat_nxt;
      out_ovf_r <= out_ovf_nxt;
    end
    scan_r   <= scan_nxt;
    fpath_r  <= fpath_nxt;
    fvis_r   <= fvis_nxt;
    nvis_r   <= nvis_nxt;
    fovf_r   <= fovf_nxt;
    fmatch_r <= fmatch_nxt;
    req_r    <= req_nxt;
    size_r   <= size_nxt;
    src_r    <= src_nxt;
    dst_r    <= dst_nxt;
    up_r     <= up_nxt;
    left_r   <= left_nxt;
    k_r      <= k_nxt;
    vptr_r   <= vptr_nxt;
    newcnt_r <= newcnt_nxt;
    rd_ok_r  <= rd_ok_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_corridor_len = out_len_r;
  assign out_read_ref     = out_ref_r;
  assign out_matched      = out_mat_r;
  assign out_overflow     = out_ovf_r;

endmodule

// ----- hdl/pcvs_checker.sv -----
// Port-level checks for the path corridor visited splice unit, bound to the
// top level. Depends on pcvs_pkg and path_corridor_visited_splice_unit.
`timescale 1ns / 1ps

module pcvs_checker
  import pcvs_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [LEN_W-1:0]  out_corridor_len,
  input logic [REF_W-1:0]  out_read_ref,
  input logic              out_matched,
  input logic              out_overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_corridor_len)
      && $stable(out_read_ref) && $stable(out_matched) && $stable(out_overflow))
    else $error("result beat changed while stalled");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_corridor_len) <= MAX_CORRIDOR))
    else $error("corridor length beyond capacity");

  a_match_no_ref: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_matched |-> (out_read_ref == '0))
    else $error("fixup beat carries read data");

  a_ovf_no_ref: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> (out_read_ref == '0))
    else $error("dropped or out-of-range beat carries read data");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result held");

endmodule

bind path_corridor_visited_splice_unit pcvs_checker u_pcvs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_corridor_len (out_corridor_len),
  .out_read_ref     (out_read_ref),
  .out_matched      (out_matched),
  .out_overflow     (out_overflow)
);

// ----- test/pcvs_checker.sv -----
// Scoreboard for the path corridor visited splice unit: tracks corridor and
// visited lists from input beats and compares every result beat.
// Depends on pcvs_pkg.
`timescale 1ns / 1ps

module pcvs_scoreboard
  import pcvs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_mode,
  input  logic [REF_W-1:0]  in_poly_ref,
  input  logic              in_first,
  input  logic              in_last,
  input  logic [RIDX_W-1:0] in_read_index,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [LEN_W-1:0]  out_corridor_len,
  input  logic [REF_W-1:0]  out_read_ref,
  input  logic              out_matched,
  input  logic              out_overflow,
  output int                errors,
  output int                pending
);

  typedef struct {
    logic [LEN_W-1:0] len;
    logic [REF_W-1:0] rd;
    logic             matched;
    logic             overflow;
  } status_t;

  status_t          status_q[$];
  logic [REF_W-1:0] corridor [MAX_CORRIDOR];
  logic [REF_W-1:0] visited [MAX_VISITED];
  int               corridor_n;
  int               visited_n;

  function automatic bit splice_visited();
    logic [REF_W-1:0] merged [MAX_CORRIDOR];
    int hit_c;
    int hit_v;
    int head;
    int tail;
    hit_c = -1;
    hit_v = 0;
    for (int i = corridor_n - 1; i >= 0 && hit_c < 0; i--)
      for (int j = visited_n - 1; j >= 0; j--)
        if (corridor[i] == visited[j]) begin
          hit_c = i;
          hit_v = j;
        end
    if (hit_c < 0)
      return 1'b0;
    head = visited_n - hit_v;
    tail = corridor_n - hit_c - 1;
    if (head > MAX_CORRIDOR) begin
      head = MAX_CORRIDOR;
      tail = 0;
    end else if (head + tail > MAX_CORRIDOR) begin
      tail = MAX_CORRIDOR - head;
    end
    for (int k = 0; k < head; k++)
      merged[k] = visited[visited_n - 1 - k];
    for (int k = 0; k < tail; k++)
      merged[head + k] = corridor[hit_c + 1 + k];
    for (int k = 0; k < head + tail; k++)
      corridor[k] = merged[k];
    corridor_n = head + tail;
    return 1'b1;
  endfunction

  function automatic status_t advance_lists(mode_t mode, logic [REF_W-1:0] poly,
                                            logic first, logic last,
                                            logic [RIDX_W-1:0] ridx);
    status_t s;
    s.rd       = '0;
    s.matched  = 1'b0;
    s.overflow = 1'b0;
    case (mode)
      MODE_COR: begin
        if (first)
          corridor_n = 0;
        if (corridor_n < MAX_CORRIDOR) begin
          corridor[corridor_n] = poly;
          corridor_n++;
        end else begin
          s.overflow = 1'b1;
        end
      end
      MODE_VIS: begin
        if (first)
          visited_n = 0;
        if (visited_n < MAX_VISITED) begin
          visited[visited_n] = poly;
          visited_n++;
        end else begin
          s.overflow = 1'b1;
        end
        if (last) begin
          s.matched = splice_visited();
          visited_n = 0;
        end
      end
      MODE_READ: begin
        if (int'(ridx) < corridor_n)
          s.rd = corridor[ridx];
        else
          s.overflow = 1'b1;
      end
      default: ;
    endcase
    s.len = LEN_W'(corridor_n);
    return s;
  endfunction

  always @(posedge clk) begin
    status_t want;
    if (!rst_n) begin
      status_q.delete();
      corridor_n = 0;
      visited_n  = 0;
      errors     = 0;
      pending   <= 0;
    end else begin
      if (in_valid && !in_stall)
        status_q = {status_q, advance_lists(mode_t'(in_mode), in_poly_ref, in_first,
                                            in_last, in_read_index)};
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          $error("result beat with no input beat waiting: corridor_len %0d",
                 out_corridor_len);
          errors++;
        end else begin
          want = status_q.pop_front();
          if (out_corridor_len !== want.len) begin
            $error("corridor_len: expected %0d, actual %0d", want.len, out_corridor_len);
            errors++;
          end
          if (out_read_ref !== want.rd) begin
            $error("read_ref: expected %h, actual %h", want.rd, out_read_ref);
            errors++;
          end
          if (out_matched !== want.matched) begin
            $error("matched: expected %b, actual %b", want.matched, out_matched);
            errors++;
          end
          if (out_overflow !== want.overflow) begin
            $error("overflow: expected %b, actual %b", want.overflow, out_overflow);
            errors++;
          end
        end
      end
      pending <= status_q.size();
    end
  end

endmodule

// ----- test/path_corridor_visited_splice_unit_test.sv -----
// Testbench top for the path corridor visited splice unit: clock, reset,
// directed and random beats, receiver stalls and the verdict.
// Depends on pcvs_pkg, pcvs_scoreboard and path_corridor_visited_splice_unit.
`timescale 1ns / 1ps

module path_corridor_visited_splice_unit_test;
  import pcvs_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_mode;
  logic [REF_W-1:0]  in_poly_ref;
  logic              in_first;
  logic              in_last;
  logic [RIDX_W-1:0] in_read_index;
  logic              out_valid;
  logic              out_stall;
  logic [LEN_W-1:0]  out_corridor_len;
  logic [REF_W-1:0]  out_read_ref;
  logic              out_matched;
  logic              out_overflow;

  int               fail_count;
  int               open_count;
  int               sent;
  int               big_builds;
  bit               tx_calm;
  logic [REF_W-1:0] built[$];

  path_corridor_visited_splice_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_poly_ref      (in_poly_ref),
    .in_first         (in_first),
    .in_last          (in_last),
    .in_read_index    (in_read_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_corridor_len (out_corridor_len),
    .out_read_ref     (out_read_ref),
    .out_matched      (out_matched),
    .out_overflow     (out_overflow)
  );

  pcvs_scoreboard i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_poly_ref      (in_poly_ref),
    .in_first         (in_first),
    .in_last          (in_last),
    .in_read_index    (in_read_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_corridor_len (out_corridor_len),
    .out_read_ref     (out_read_ref),
    .out_matched      (out_matched),
    .out_overflow     (out_overflow),
    .errors           (fail_count),
    .pending          (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [REF_W-1:0] pool_ref();
    if ($urandom_range(0, 3) == 0)
      return $urandom;
    return $urandom_range(0, 47);
  endfunction

  function automatic logic [REF_W-1:0] visit_ref();
    int pick;
    pick = $urandom_range(0, 5);
    if (built.size() > 0 && pick == 0)
      return built[$urandom_range(0, (built.size() > 4) ? 3 : built.size() - 1)];
    if (built.size() > 0 && pick == 1)
      return built[$urandom_range(0, built.size() - 1)];
    if (pick == 2)
      return $urandom;
    return $urandom_range(0, 47);
  endfunction

  task automatic send(mode_t mode, logic [REF_W-1:0] poly, logic first, logic last,
                      logic [RIDX_W-1:0] ridx);
    int gap;
    if (sent % 32 == 0)
      tx_calm = ($urandom_range(0, 3) == 0);
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_poly_ref   <= poly;
    in_first      <= first;
    in_last       <= last;
    in_read_index <= ridx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic build_corridor(int n, bit wide);
    logic [REF_W-1:0] poly;
    built.delete();
    for (int k = 0; k < n; k++) begin
      poly = wide ? $urandom : pool_ref();
      built = {built, poly};
      send(MODE_COR, poly, k == 0, 1'($urandom_range(0, 1)), RIDX_W'($urandom));
    end
  endtask

  task automatic walk_visited(int n);
    for (int k = 0; k < n; k++)
      send(MODE_VIS, visit_ref(), k == 0, k == n - 1, RIDX_W'($urandom));
  endtask

  // receiver: per-beat hold-off, with one long hold to back up the input
  initial begin
    int  hold;
    int  rx_beats;
    bit  rx_calm;
    out_stall = 1'b0;
    rx_beats  = 0;
    rx_calm   = 1'b0;
    forever begin
      if (rx_beats % 32 == 0)
        rx_calm = ($urandom_range(0, 3) == 0);
      hold = rx_calm ? 0 : $urandom_range(0, 7);
      if (rx_beats == 150)
        hold = 400;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      rx_beats++;
    end
  end

  initial begin
    int pick;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_mode       = MODE_NOP;
    in_poly_ref   = '0;
    in_first      = 1'b0;
    in_last       = 1'b0;
    in_read_index = '0;
    sent          = 0;
    big_builds    = 0;
    tx_calm       = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send(MODE_READ, 32'h0, 1'b0, 1'b0, 8'd0);
    send(MODE_NOP, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF);
    send(MODE_COR, 32'h0, 1'b1, 1'b0, 8'd0);
    send(MODE_COR, 32'hFFFF_FFFF, 1'b0, 1'b1, 8'd0);
    send(MODE_COR, 32'h5, 1'b0, 1'b0, 8'd0);
    send(MODE_COR, 32'h5, 1'b0, 1'b0, 8'd0);
    send(MODE_READ, 32'h0, 1'b0, 1'b0, 8'd0);
    send(MODE_READ, 32'h0, 1'b0, 1'b0, 8'd3);
    send(MODE_READ, 32'h0, 1'b0, 1'b0, 8'd4);
    send(MODE_READ, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'd255);
    send(MODE_VIS, 32'h1234_5678, 1'b1, 1'b0, 8'd0);
    send(MODE_VIS, 32'hFFFF_FFFF, 1'b0, 1'b1, 8'd0);
    send(MODE_VIS, 32'hDEAD_BEEF, 1'b1, 1'b1, 8'd0);
    send(MODE_VIS, 32'h5, 1'b1, 1'b0, 8'd0);
    send(MODE_VIS, 32'h5, 1'b0, 1'b0, 8'd0);
    send(MODE_VIS, 32'h7, 1'b0, 1'b1, 8'd0);
    send(MODE_READ, 32'h0, 1'b0, 1'b0, 8'd0);
    send(MODE_READ, 32'h0, 1'b0, 1'b0, 8'd2);
    send(MODE_VIS, 32'h7, 1'b0, 1'b1, 8'd0);
    send(MODE_COR, 32'h9, 1'b1, 1'b0, 8'd0);
    send(MODE_COR, 32'h8000_0000, 1'b0, 1'b1, 8'd0);

    while (sent < 600) begin
      pick = $urandom_range(0, 9);
      if (sent > 60 && sent < 340 && big_builds < 2 && $urandom_range(0, 11) == 0) begin
        big_builds++;
        build_corridor($urandom_range(250, 260), 1'b1);
      end else if (pick <= 3) begin
        build_corridor($urandom_range(1, 24), 1'b0);
      end else if (pick <= 6) begin
        walk_visited(($urandom_range(0, 4) == 0) ? $urandom_range(15, 18)
                                                 : $urandom_range(1, 8));
      end else if (pick <= 8) begin
        repeat ($urandom_range(1, 4))
          send(MODE_READ, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               RIDX_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 31)));
      end else begin
        send(mode_t'($urandom_range(0, 3)), pool_ref(), 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)), RIDX_W'($urandom));
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/pcvs_pkg.sv
hdl/pcvs_cor_ram.sv
hdl/pcvs_vis_list.sv
hdl/path_corridor_visited_splice_unit.sv
hdl/pcvs_checker.sv
test/pcvs_checker.sv
test/path_corridor_visited_splice_unit_test.sv
